// ===== hw/rtl/hss_pkg.sv =====
// types, constants and the rotation angle table for the hyperbolic spiral surface evaluator
// no dependencies; used by every module of the block
package hss_pkg;

    // widths
    localparam int U_W          = 24;
    localparam int OUT_W        = 32;
    localparam int TRIG_W       = 34;
    localparam int RED_W        = 39;
    localparam int DEN_W        = 23;
    localparam int DIV_NW       = 36;
    localparam int CORDIC_STEPS = 30;

    // pipeline depths
    localparam int RED_LAT   = 4;
    localparam int TRIG_LAT  = RED_LAT + CORDIC_STEPS;
    localparam int DIV_LAT   = DIV_NW + 1;
    localparam int POLY_LAT  = 4;
    localparam int PAD_LAT   = DIV_LAT - POLY_LAT;
    localparam int TOTAL_LAT = TRIG_LAT + DIV_LAT;

    // angle constants in Q2.30
    localparam logic signed [RED_W-1:0] ANG_TWO_PI  = 39'sd6746518852;
    localparam logic signed [RED_W-1:0] ANG_PI      = 39'sd3373259426;
    localparam logic signed [RED_W-1:0] ANG_HALF_PI = 39'sd1686629713;

    localparam logic signed [TRIG_W-1:0] ROT_GAIN = 34'sd652032874;
    localparam logic signed [TRIG_W-1:0] ONE_Q30  = 34'sd1073741824;

    // near-zero u handling
    localparam logic signed [U_W-1:0]   SMALL_U_RAW = 24'sd65;
    localparam logic signed [OUT_W-1:0] PX_SMALL    = 32'sd65536000;
    localparam logic signed [OUT_W-1:0] PZ_SMALL    = 32'sd65536;

    localparam logic signed [U_W-1:0] H_RESET = 24'sd65536;

    typedef struct packed {
        logic signed [U_W-1:0] param_u;
        logic signed [U_W-1:0] param_v;
    } in_word_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] point_x;
        logic signed [OUT_W-1:0] point_y;
        logic signed [OUT_W-1:0] point_z;
        logic signed [OUT_W-1:0] du_x;
        logic signed [OUT_W-1:0] du_z;
        logic signed [OUT_W-1:0] dv_y;
        logic signed [OUT_W-1:0] normal_x;
        logic signed [OUT_W-1:0] normal_z;
        logic signed [OUT_W-1:0] duu_x;
        logic signed [OUT_W-1:0] duu_z;
    } out_word_t;

    // sine / cosine with the parameters that travel alongside
    typedef struct packed {
        logic                     valid;
        logic signed [TRIG_W-1:0] c;
        logic signed [TRIG_W-1:0] s;
        logic signed [U_W-1:0]    u;
        logic signed [U_W-1:0]    v;
    } trig_t;

    typedef struct packed {
        logic                     valid;
        logic                     near_zero;
        logic signed [TRIG_W-1:0] c;
        logic signed [TRIG_W-1:0] s;
        logic signed [U_W-1:0]    u;
        logic signed [U_W-1:0]    v;
    } poly_in_t;

    typedef struct packed {
        logic      valid;
        logic      near_zero;
        out_word_t word;
    } poly_out_t;

    // atan(2^-i) in Q2.30
    function automatic logic signed [TRIG_W-1:0] rot_angle(input int idx);
        logic signed [TRIG_W-1:0] a;
        case (idx)
            0:  a = 34'sd843314857;
            1:  a = 34'sd497837829;
            2:  a = 34'sd263043837;
            3:  a = 34'sd133525159;
            4:  a = 34'sd67021687;
            5:  a = 34'sd33543516;
            6:  a = 34'sd16775851;
            7:  a = 34'sd8388437;
            8:  a = 34'sd4194283;
            9:  a = 34'sd2097149;
            10: a = 34'sd1048576;
            11: a = 34'sd524288;
            12: a = 34'sd262144;
            13: a = 34'sd131072;
            14: a = 34'sd65536;
            15: a = 34'sd32768;
            16: a = 34'sd16384;
            17: a = 34'sd8192;
            18: a = 34'sd4096;
            19: a = 34'sd2048;
            20: a = 34'sd1024;
            21: a = 34'sd512;
            22: a = 34'sd256;
            23: a = 34'sd128;
            24: a = 34'sd64;
            25: a = 34'sd32;
            26: a = 34'sd16;
            27: a = 34'sd8;
            28: a = 34'sd4;
            29: a = 34'sd2;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== hw/rtl/hss_cordic.sv =====
// angle reduction into [-pi/2, pi/2] and a 30-stage rotation pipeline for sin and cos
// depends on hss_pkg
module hss_cordic (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic signed [hss_pkg::U_W-1:0]    in_u,
    input  logic signed [hss_pkg::U_W-1:0]    in_v,
    output hss_pkg::trig_t                    trig
);

    localparam int N  = hss_pkg::CORDIC_STEPS;
    localparam int RW = hss_pkg::RED_W;
    localparam int TW = hss_pkg::TRIG_W;
    localparam int UW = hss_pkg::U_W;

    localparam logic signed [RW-1:0] K1  = hss_pkg::ANG_TWO_PI;
    localparam logic signed [RW-1:0] K2  = hss_pkg::ANG_TWO_PI <<< 1;
    localparam logic signed [RW-1:0] K4  = hss_pkg::ANG_TWO_PI <<< 2;
    localparam logic signed [RW-1:0] K8  = hss_pkg::ANG_TWO_PI <<< 3;
    localparam logic signed [RW-1:0] K16 = hss_pkg::ANG_TWO_PI <<< 4;

    function automatic logic signed [RW-1:0] csub(input logic signed [RW-1:0] r,
                                                  input logic signed [RW-1:0] k);
        return (r >= k) ? r - k : r;
    endfunction

    logic signed [RW-1:0] ang_in;
    logic signed [RW-1:0] r1_next, r2_next, r3_next, r3_part, fold_next;
    logic                 flip_next;
    logic signed [RW-1:0] r1_reg, r2_reg, r3_reg;
    logic signed [UW-1:0] u1_reg, u2_reg, u3_reg, v1_reg, v2_reg, v3_reg;
    logic                 vld1_reg, vld2_reg, vld3_reg;

    logic signed [TW-1:0] x_reg [0:N];
    logic signed [TW-1:0] y_reg [0:N];
    logic signed [TW-1:0] z_reg [0:N];
    logic                 flip_reg [0:N];
    logic signed [UW-1:0] u_reg [0:N];
    logic signed [UW-1:0] v_reg [0:N];
    logic                 vld_reg [0:N];

    // modulo 2pi by conditional subtraction, two multiples per stage
    assign ang_in  = $signed({in_u[UW-1], in_u, 14'b0});
    assign r1_next = csub(csub(ang_in, K16), K8);
    assign r2_next = csub(csub(r1_reg, K4), K2);
    assign r3_part = csub(r2_reg, K1);
    assign r3_next = (r3_part > hss_pkg::ANG_PI) ? r3_part - K1 : r3_part;

    // fold into [-pi/2, pi/2], cosine changes sign
    always_comb
    begin
        fold_next = r3_reg;
        flip_next = 1'b0;
        if (r3_reg > hss_pkg::ANG_HALF_PI)
        begin
            fold_next = hss_pkg::ANG_PI - r3_reg;
            flip_next = 1'b1;
        end
        else if (r3_reg < -hss_pkg::ANG_HALF_PI)
        begin
            fold_next = -hss_pkg::ANG_PI - r3_reg;
            flip_next = 1'b1;
        end
    end

    // reduction stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg   <= 1'b0;
            vld2_reg   <= 1'b0;
            vld3_reg   <= 1'b0;
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld1_reg   <= in_valid;
            vld2_reg   <= vld1_reg;
            vld3_reg   <= vld2_reg;
            vld_reg[0] <= vld3_reg;
        end
    end

    // reduction stage data
    always_ff @(posedge clk)
    begin
        r1_reg      <= r1_next;
        u1_reg      <= in_u;
        v1_reg      <= in_v;
        r2_reg      <= r2_next;
        u2_reg      <= u1_reg;
        v2_reg      <= v1_reg;
        r3_reg      <= r3_next;
        u3_reg      <= u2_reg;
        v3_reg      <= v2_reg;
        x_reg[0]    <= hss_pkg::ROT_GAIN;
        y_reg[0]    <= '0;
        z_reg[0]    <= fold_next[TW-1:0];
        flip_reg[0] <= flip_next;
        u_reg[0]    <= u3_reg;
        v_reg[0]    <= v3_reg;
    end

    // one rotation per stage
    for (genvar i = 0; i < N; i++)
    begin : g_rot
        logic signed [TW-1:0] x_next, y_next, z_next;

        always_comb
        begin
            if (z_reg[i] >= 0)
            begin
                x_next = x_reg[i] - (y_reg[i] >>> i);
                y_next = y_reg[i] + (x_reg[i] >>> i);
                z_next = z_reg[i] - hss_pkg::rot_angle(i);
            end
            else
            begin
                x_next = x_reg[i] + (y_reg[i] >>> i);
                y_next = y_reg[i] - (x_reg[i] >>> i);
                z_next = z_reg[i] + hss_pkg::rot_angle(i);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[i+1]    <= x_next;
            y_reg[i+1]    <= y_next;
            z_reg[i+1]    <= z_next;
            flip_reg[i+1] <= flip_reg[i];
            u_reg[i+1]    <= u_reg[i];
            v_reg[i+1]    <= v_reg[i];
        end
    end

    assign trig.valid = vld_reg[N];
    assign trig.c     = flip_reg[N] ? -x_reg[N] : x_reg[N];
    assign trig.s     = y_reg[N];
    assign trig.u     = u_reg[N];
    assign trig.v     = v_reg[N];

endmodule

// ===== hw/rtl/hss_div.sv =====
// pipelined restoring divider, one quotient bit per stage, round half away from zero
// depends on hss_pkg
module hss_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic signed [hss_pkg::DIV_NW-1:0]   in_num,
    input  logic        [hss_pkg::DEN_W-1:0]    in_den,
    output logic                                out_valid,
    output logic signed [hss_pkg::OUT_W-1:0]    out_quo
);

    localparam int NW = hss_pkg::DIV_NW;
    localparam int DW = hss_pkg::DEN_W;

    logic [NW-1:0] mag;
    logic [NW-1:0] nq_reg  [0:NW];
    logic [DW-1:0] rem_reg [0:NW];
    logic [DW-1:0] den_reg [0:NW];
    logic          neg_reg [0:NW];
    logic          vld_reg [0:NW];
    logic signed [NW-1:0] quo;

    // magnitude plus half the divisor
    assign mag = in_num[NW-1] ? NW'(-in_num) : NW'(in_num);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        nq_reg[0]  <= mag + NW'(in_den >> 1);
        rem_reg[0] <= '0;
        den_reg[0] <= in_den;
        neg_reg[0] <= in_num[NW-1];
    end

    // one trial subtraction per stage
    for (genvar k = 0; k < NW; k++)
    begin : g_step
        logic [DW:0] sh, diff;
        logic        ge;

        assign sh   = {rem_reg[k], nq_reg[k][NW-1]};
        assign diff = sh - {1'b0, den_reg[k]};
        assign ge   = (sh >= {1'b0, den_reg[k]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= ge ? diff[DW-1:0] : sh[DW-1:0];
            nq_reg[k+1]  <= {nq_reg[k][NW-2:0], ge};
            den_reg[k+1] <= den_reg[k];
            neg_reg[k+1] <= neg_reg[k];
        end
    end

    // quotient fits the output width except for near-zero words, whose quotients are replaced
    assign quo       = neg_reg[NW] ? -$signed(nq_reg[NW]) : $signed(nq_reg[NW]);
    assign out_quo   = quo[hss_pkg::OUT_W-1:0];
    assign out_valid = vld_reg[NW];

endmodule

// ===== hw/rtl/hss_poly.sv =====
// polynomial terms in u, sin and cos, plus H*v; four register stages
// depends on hss_pkg
module hss_poly (
    input  logic                              clk,
    input  logic                              rst_n,
    input  hss_pkg::poly_in_t                 pin,
    input  logic signed [hss_pkg::U_W-1:0]    h,
    output hss_pkg::poly_out_t                pout
);

    localparam int TW = hss_pkg::TRIG_W;
    localparam int OW = hss_pkg::OUT_W;
    localparam int PW = 58;
    localparam int SW = 66;

    function automatic logic signed [OW-1:0] rnd_sat(input logic signed [SW-1:0] a);
        logic signed [SW-1:0] t;
        t = (a + (SW'(1) <<< 29)) >>> 30;
        if (t > SW'(32'sh7fffffff))
            return 32'sh7fffffff;
        else if (t < SW'(-33'sd2147483648))
            return 32'sh80000000;
        else
            return t[OW-1:0];
    endfunction

    logic vld1_reg, vld2_reg, vld3_reg, vld4_reg;
    logic sml1_reg, sml2_reg, sml3_reg, sml4_reg;

    // stage 1
    logic signed [PW-1:0] uc1_reg, us1_reg;
    logic        [30:0]   u2_1_reg;
    logic signed [47:0]   vh1_reg;
    logic signed [TW-1:0] c1_reg, s1_reg;
    logic signed [47:0]   uu;

    // stage 2
    logic signed [PW-1:0] uc2_reg, us2_reg;
    logic signed [SW-1:0] u2c2_reg, u2s2_reg;
    logic signed [OW-1:0] py2_reg, py3_reg, py4_reg;
    logic signed [TW-1:0] c2_reg, s2_reg;
    logic signed [47:0]   vh_rnd;

    // stage 3
    logic signed [SW-1:0] c46, s46, uc_w, us_w;
    logic signed [SW-1:0] da3_reg, db3_reg, dn3_reg, xx3_reg, zz3_reg;

    // stage 4
    logic signed [OW-1:0] du_x4_reg, du_z4_reg, nx4_reg, xx4_reg, zz4_reg;

    assign uu = 48'(pin.u) * 48'(pin.u);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= pin.valid;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
        end
    end

    // products with u and u^2 rounded to Q16
    always_ff @(posedge clk)
    begin
        uc1_reg  <= PW'(pin.u) * PW'(pin.c);
        us1_reg  <= PW'(pin.u) * PW'(pin.s);
        u2_1_reg <= 31'((uu + 48'sd32768) >>> 16);
        vh1_reg  <= 48'(pin.v) * 48'(h);
        c1_reg   <= pin.c;
        s1_reg   <= pin.s;
        sml1_reg <= pin.near_zero;
    end

    // u^2 times cos and sin, H*v rounded
    assign vh_rnd = (vh1_reg + 48'sd32768) >>> 16;

    always_ff @(posedge clk)
    begin
        u2c2_reg <= SW'($signed({1'b0, u2_1_reg})) * SW'(c1_reg);
        u2s2_reg <= SW'($signed({1'b0, u2_1_reg})) * SW'(s1_reg);
        py2_reg  <= vh_rnd[OW-1:0];
        uc2_reg  <= uc1_reg;
        us2_reg  <= us1_reg;
        c2_reg   <= c1_reg;
        s2_reg   <= s1_reg;
        sml2_reg <= sml1_reg;
    end

    // Q46 sums
    assign c46  = SW'(c2_reg) <<< 16;
    assign s46  = SW'(s2_reg) <<< 16;
    assign uc_w = SW'(uc2_reg);
    assign us_w = SW'(us2_reg);

    always_ff @(posedge clk)
    begin
        da3_reg  <= -(c46 + us_w);
        db3_reg  <= uc_w - s46;
        dn3_reg  <= s46 - uc_w;
        xx3_reg  <= (c46 <<< 1) + (us_w <<< 1) - u2c2_reg;
        zz3_reg  <= (s46 <<< 1) - (uc_w <<< 1) - u2s2_reg;
        py3_reg  <= py2_reg;
        sml3_reg <= sml2_reg;
    end

    // round to Q16 and saturate
    always_ff @(posedge clk)
    begin
        du_x4_reg <= rnd_sat(da3_reg);
        du_z4_reg <= rnd_sat(db3_reg);
        nx4_reg   <= rnd_sat(dn3_reg);
        xx4_reg   <= rnd_sat(xx3_reg);
        zz4_reg   <= rnd_sat(zz3_reg);
        py4_reg   <= py3_reg;
        sml4_reg  <= sml3_reg;
    end

    assign pout.valid         = vld4_reg;
    assign pout.near_zero     = sml4_reg;
    assign pout.word.point_x  = '0;
    assign pout.word.point_y  = py4_reg;
    assign pout.word.point_z  = '0;
    assign pout.word.du_x     = du_x4_reg;
    assign pout.word.du_z     = du_z4_reg;
    assign pout.word.dv_y     = OW'(h);
    assign pout.word.normal_x = nx4_reg;
    assign pout.word.normal_z = du_x4_reg;
    assign pout.word.duu_x    = xx4_reg;
    assign pout.word.duu_z    = zz4_reg;

endmodule

// ===== hw/rtl/hyperbolic_spiral_surface_eval.sv =====
// hyperbolic spiral surface evaluator: point, derivatives and normal for each (u, v) word
// from start to done a word passes 4 reduction and 30 rotation stages, then 37 divider stages
// throughput one word per cycle; busy stays low and the result is never held off
// reset clears every valid bit and sets the height scale to 1.0; depends on hss_pkg
module hyperbolic_spiral_surface_eval (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  hss_pkg::in_word_t                   item,
    input  logic                                cfg_wr_en,
    input  logic signed [hss_pkg::U_W-1:0]      cfg_wr_data,
    output logic                                done,
    output hss_pkg::out_word_t                  result
);

    localparam int PAD = hss_pkg::PAD_LAT;
    localparam int TW  = hss_pkg::TRIG_W;

    logic signed [hss_pkg::U_W-1:0] height_scale_reg;
    hss_pkg::trig_t     trig;
    hss_pkg::poly_in_t  sel;
    hss_pkg::poly_in_t  pad_reg [0:PAD-1];
    hss_pkg::poly_out_t pout;
    logic               near_zero;
    logic               div_valid;
    logic signed [hss_pkg::OUT_W-1:0] qx, qz;

    assign busy = 1'b0;

    // height scale register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_scale_reg <= hss_pkg::H_RESET;
        end
        else if (cfg_wr_en)
        begin
            height_scale_reg <= cfg_wr_data;
        end
    end

    hss_cordic u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .in_u     (item.param_u),
        .in_v     (item.param_v),
        .trig     (trig)
    );

    // near-zero or negative u takes cos 1, sin 0
    assign near_zero     = !(trig.u > hss_pkg::SMALL_U_RAW);
    assign sel.valid     = trig.valid;
    assign sel.near_zero = near_zero;
    assign sel.c         = near_zero ? hss_pkg::ONE_Q30 : trig.c;
    assign sel.s         = near_zero ? TW'(0) : trig.s;
    assign sel.u         = trig.u;
    assign sel.v         = trig.v;

    hss_div u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sel.valid),
        .in_num    (hss_pkg::DIV_NW'(sel.c) <<< 2),
        .in_den    (near_zero ? hss_pkg::DEN_W'(1) : trig.u[hss_pkg::DEN_W-1:0]),
        .out_valid (div_valid),
        .out_quo   (qx)
    );

    hss_div u_div_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sel.valid),
        .in_num    (hss_pkg::DIV_NW'(sel.s) <<< 2),
        .in_den    (near_zero ? hss_pkg::DEN_W'(1) : trig.u[hss_pkg::DEN_W-1:0]),
        .out_valid (),
        .out_quo   (qz)
    );

    // delay line so the polynomial terms line up with the quotients
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PAD; i++)
            begin
                pad_reg[i] <= '0;
            end
        end
        else
        begin
            pad_reg[0] <= sel;
            for (int i = 1; i < PAD; i++)
            begin
                pad_reg[i] <= pad_reg[i-1];
            end
        end
    end

    hss_poly u_poly (
        .clk   (clk),
        .rst_n (rst_n),
        .pin   (pad_reg[PAD-1]),
        .h     (height_scale_reg),
        .pout  (pout)
    );

    // merge quotients into the result word
    always_comb
    begin
        result         = pout.word;
        result.point_x = pout.near_zero ? hss_pkg::PX_SMALL : qx;
        result.point_z = pout.near_zero ? hss_pkg::PZ_SMALL : qz;
    end

    assign done = pout.valid;

    // both paths deliver in the same cycle
    a_align: assert property (@(posedge clk) disable iff (!rst_n)
        div_valid == pout.valid)
        else $error("divider and polynomial paths out of step");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(hss_pkg::TOTAL_LAT) done)
        else $error("accepted word did not come out on time");

    a_small: assert property (@(posedge clk) disable iff (!rst_n)
        (done && pout.near_zero) |-> (result.point_x == hss_pkg::PX_SMALL &&
                                      result.point_z == hss_pkg::PZ_SMALL))
        else $error("near-zero u did not use fixed point values");

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the hyperbolic spiral surface evaluator
// drives command words and height scale writes, predicts every result word and compares
// depends on hss_pkg and hyperbolic_spiral_surface_eval
`timescale 1ns / 100ps

module tb_top;

    localparam int  DRAIN_CYCLES = hss_pkg::TOTAL_LAT + 10;
    localparam int  STALL_LIMIT  = 4000;
    localparam longint TWO_PI_Q30  = 64'sd6746518852;
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    typedef enum logic [1:0] {JOB_WORD, JOB_SCALE, JOB_SETTLE, JOB_IDLE} job_kind_t;

    typedef struct {
        job_kind_t         kind;
        hss_pkg::in_word_t word;
        logic [hss_pkg::U_W-1:0] scale;
        int                idle_pct;
    } job_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    hss_pkg::in_word_t item = '0;
    logic       cfg_wr_en = 1'b0;
    logic signed [hss_pkg::U_W-1:0] cfg_wr_data = '0;
    logic       done;
    hss_pkg::out_word_t result;

    job_t       pending_jobs[$];
    hss_pkg::out_word_t expected_words[$];
    logic signed [hss_pkg::U_W-1:0] height_scale = hss_pkg::H_RESET;
    int         idle_pct = 0;
    int         quiet_cycles = 0;
    int         stall_cycles = 0;
    bit         failed = 1'b0;

    hyperbolic_spiral_surface_eval i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .done        (done),
        .result      (result)
    );

    always #5 clk = ~clk;

    // saturate to the signed 32-bit result range
    function automatic logic [hss_pkg::OUT_W-1:0] clamp32(input longint val);
        if (val > 64'sd2147483647)
            return 32'h7fff_ffff;
        if (val < -64'sd2147483648)
            return 32'h8000_0000;
        return val[hss_pkg::OUT_W-1:0];
    endfunction

    // add half, then floor shift
    function automatic longint round_down_shift(input longint val, input int sh);
        return (val + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    // quotient rounded half away from zero
    function automatic longint quot_round(input longint num, input longint den);
        if (num >= 0)
            return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    // spiral surface terms for one word
    function automatic hss_pkg::out_word_t surface_terms(input hss_pkg::in_word_t w,
                                                        input logic signed [hss_pkg::U_W-1:0] hs);
        hss_pkg::out_word_t o;
        longint u, v, h, c, s, px, pz, u2, c46, s46, uc, us, r, x, y, nx;
        bit flip;
        u = w.param_u;
        v = w.param_v;
        h = hs;
        flip = 1'b0;
        if (u > longint'(hss_pkg::SMALL_U_RAW))
        begin
            // reduce angle to [-pi/2, pi/2], then rotate
            r = (u * 16384) % TWO_PI_Q30;
            if (r > PI_Q30)
                r = r - TWO_PI_Q30;
            else if (r < -PI_Q30)
                r = r + TWO_PI_Q30;
            if (r > HALF_PI_Q30)
            begin
                r = PI_Q30 - r;
                flip = 1'b1;
            end
            else if (r < -HALF_PI_Q30)
            begin
                r = -PI_Q30 - r;
                flip = 1'b1;
            end
            x = hss_pkg::ROT_GAIN;
            y = 0;
            for (int i = 0; i < hss_pkg::CORDIC_STEPS; i++)
            begin
                if (r >= 0)
                begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    r  = r - longint'(hss_pkg::rot_angle(i));
                end
                else
                begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    r  = r + longint'(hss_pkg::rot_angle(i));
                end
                x = nx;
            end
            c = flip ? -x : x;
            s = y;
            px = quot_round(4 * c, u);
            pz = quot_round(4 * s, u);
        end
        else
        begin
            c = hss_pkg::ONE_Q30;
            s = 0;
            px = hss_pkg::PX_SMALL;
            pz = hss_pkg::PZ_SMALL;
        end
        u2  = longint'((64'(u * u) + 64'd32768) >> 16);
        c46 = c * 65536;
        s46 = s * 65536;
        uc  = u * c;
        us  = u * s;
        o.point_x  = clamp32(px);
        o.point_y  = clamp32(round_down_shift(v * h, 16));
        o.point_z  = clamp32(pz);
        o.du_x     = clamp32(round_down_shift(-(c46 + us), 30));
        o.du_z     = clamp32(round_down_shift(uc - s46, 30));
        o.dv_y     = clamp32(h);
        o.normal_x = clamp32(round_down_shift(s46 - uc, 30));
        o.normal_z = clamp32(round_down_shift(-(c46 + us), 30));
        o.duu_x    = clamp32(round_down_shift(2 * c46 + 2 * us - u2 * c, 30));
        o.duu_z    = clamp32(round_down_shift(2 * s46 - 2 * uc - u2 * s, 30));
        return o;
    endfunction

    // driver: words, scale writes and idle control from the job queue
    always @(posedge clk)
    begin
        logic next_start;
        logic next_wr;
        next_start = 1'b0;
        next_wr = 1'b0;
        if (rst_n)
        begin
            if (start && !busy)
                expected_words.push_back(surface_terms(item, height_scale));
            if (expected_words.size() == 0)
                quiet_cycles = quiet_cycles + 1;
            else
                quiet_cycles = 0;
            if (start && busy)
                next_start = 1'b1;
            else if (pending_jobs.size() > 0)
            begin
                case (pending_jobs[0].kind)
                    JOB_WORD:
                        if ($urandom_range(99) >= idle_pct)
                        begin
                            next_start = 1'b1;
                            item <= pending_jobs[0].word;
                            void'(pending_jobs.pop_front());
                        end
                    JOB_SCALE:
                        if (!start && quiet_cycles >= DRAIN_CYCLES)
                        begin
                            next_wr = 1'b1;
                            cfg_wr_data  <= pending_jobs[0].scale;
                            height_scale <= pending_jobs[0].scale;
                            void'(pending_jobs.pop_front());
                        end
                    JOB_SETTLE:
                        if (!start && expected_words.size() == 0)
                            void'(pending_jobs.pop_front());
                    default:
                    begin
                        idle_pct = pending_jobs[0].idle_pct;
                        void'(pending_jobs.pop_front());
                    end
                endcase
            end
        end
        start <= next_start;
        cfg_wr_en <= next_wr;
    end

    // monitor: compare each result word with the oldest prediction
    always @(posedge clk)
    begin
        hss_pkg::out_word_t want;
        if (rst_n && done)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word %h", $time, result);
                failed = 1'b1;
            end
            else
            begin
                want = expected_words.pop_front();
                if (want.point_x !== result.point_x)
                    $display("%0t: point_x exp %0d got %0d", $time, want.point_x,
                             result.point_x);
                if (want.point_y !== result.point_y)
                    $display("%0t: point_y exp %0d got %0d", $time, want.point_y,
                             result.point_y);
                if (want.point_z !== result.point_z)
                    $display("%0t: point_z exp %0d got %0d", $time, want.point_z,
                             result.point_z);
                if (want.du_x !== result.du_x)
                    $display("%0t: du_x exp %0d got %0d", $time, want.du_x, result.du_x);
                if (want.du_z !== result.du_z)
                    $display("%0t: du_z exp %0d got %0d", $time, want.du_z, result.du_z);
                if (want.dv_y !== result.dv_y)
                    $display("%0t: dv_y exp %0d got %0d", $time, want.dv_y, result.dv_y);
                if (want.normal_x !== result.normal_x)
                    $display("%0t: normal_x exp %0d got %0d", $time, want.normal_x,
                             result.normal_x);
                if (want.normal_z !== result.normal_z)
                    $display("%0t: normal_z exp %0d got %0d", $time, want.normal_z,
                             result.normal_z);
                if (want.duu_x !== result.duu_x)
                    $display("%0t: duu_x exp %0d got %0d", $time, want.duu_x, result.duu_x);
                if (want.duu_z !== result.duu_z)
                    $display("%0t: duu_z exp %0d got %0d", $time, want.duu_z, result.duu_z);
                if (want !== result)
                    failed = 1'b1;
            end
        end
    end

    // watchdog on cycles with no accepted word, result word or scale write
    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_wr_en || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic add_word(input logic [hss_pkg::U_W-1:0] u,
                            input logic [hss_pkg::U_W-1:0] v);
        job_t j;
        j.kind = JOB_WORD;
        j.word.param_u = u;
        j.word.param_v = v;
        j.scale = '0;
        j.idle_pct = 0;
        pending_jobs.push_back(j);
    endtask

    task automatic add_ctrl(input job_kind_t kind, input logic [hss_pkg::U_W-1:0] scale,
                            input int pct);
        job_t j;
        j.kind = kind;
        j.word = '0;
        j.scale = scale;
        j.idle_pct = pct;
        pending_jobs.push_back(j);
    endtask

    // u in the trig range or the full range in equal shares, some near the small-u threshold
    function automatic logic [hss_pkg::U_W-1:0] rand_u();
        int pick;
        pick = $urandom_range(9);
        if (pick < 2)
            return hss_pkg::U_W'($urandom_range(130) - 65);
        if (pick < 6)
            return hss_pkg::U_W'($urandom_range(66, 1 << 20));
        return hss_pkg::U_W'($urandom);
    endfunction

    initial
    begin
        int scales[5];
        int pcts[4];
        scales = '{65536, 8388607, -8388608, 0, -1};
        pcts = '{0, 69, 20, 0};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed words under the reset scale
        add_word(0, 0);
        add_word(1, 1);
        add_word(65, 24'h7fffff);
        add_word(66, 24'h800000);
        add_word(24'hffffff, 65536);
        add_word(24'h800000, 24'h800000);
        add_word(24'h7fffff, 24'h7fffff);
        add_word(65536, 65536);
        add_word(102944, 3);
        add_word(205887, 24'hffff00);
        add_word(308831, 12345);
        add_word(411775, 0);
        add_word(1000, 24'h800000);
        add_word(5000000, 24'h7fffff);
        add_ctrl(JOB_SETTLE, 0, 0);

        // phases over several scale settings and idle rates
        for (int ph = 0; ph < 6; ph++)
        begin
            add_ctrl(JOB_SCALE, (ph < 5) ? hss_pkg::U_W'(scales[ph]) :
                                           hss_pkg::U_W'($urandom), 0);
            add_word(24'h7fffff, 24'h7fffff);
            add_word(24'h800000, 24'h800000);
            for (int k = 0; k < 4; k++)
            begin
                add_ctrl(JOB_IDLE, 0, pcts[k]);
                for (int n = 0; n < 75; n++)
                    add_word(rand_u(), hss_pkg::U_W'($urandom));
                if (k == 1)
                    add_ctrl(JOB_SETTLE, 0, 0);
            end
        end

        wait (pending_jobs.size() == 0 && !start);
        wait (expected_words.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (!failed)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
